[hw/rtl/great_circle_distance_core_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define GCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define GCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gcd_pkg.sv]
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int DIST_FRAC_BITS  = 8;

    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int MAG_W  = LON_W + 1;
    localparam int BANG_W = 32;
    localparam int DIST_W = 23;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int CW           = 34;

    typedef logic signed [CW-1:0] cw_t;

    localparam cw_t GAIN_INV = 34'sd652032874;

    // degrees * 2^F -> binary angle: q = floor((m * 2^BIN_SHIFT + HALF_BIAS) / 45)
    localparam int BIN_SHIFT = 32 - ANGLE_FRAC_BITS - 3;
    localparam int HALF_BIAS = 180 / 8;
    localparam int DIV_N     = 45;
    localparam int RECIP_HI_K = 31;
    localparam logic [MAG_W-1:0] RECIP_HI = 26'd47721859;
    localparam int RECIP_LO_K = 25;
    localparam logic [19:0] RECIP_LO = 20'd745655;
    localparam int QUOT_W = 20;
    localparam int REM_W  = 6;
    localparam int LO_W   = BIN_SHIFT;

    localparam logic [15:0] KM_PER_TURN = 16'd39996;
    localparam logic [31:0] DIST_MAX = 32'((64'd1 << DIST_W) - 64'd1);

    localparam int PIPE_PRE = 5;
    localparam int SC_LAT   = CORDIC_STEPS + 1;
    localparam int PIPE_MID = 4;
    localparam int AC_LAT   = 3 + SQRT_STEPS + CORDIC_STEPS + 1;
    localparam int PIPE_DEPTH = PIPE_PRE + SC_LAT + PIPE_MID + AC_LAT + 1;

    function automatic logic [31:0] atan_tab(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/gcd_sincos.sv]
module gcd_sincos
    import gcd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [BANG_W-1:0] ang,
    output cw_t               sin_out,
    output cw_t               cos_out
);

    cw_t  x_reg   [0:CORDIC_STEPS];
    cw_t  y_reg   [0:CORDIC_STEPS];
    cw_t  z_reg   [0:CORDIC_STEPS];
    logic neg_reg [0:CORDIC_STEPS];

    logic [BANG_W-1:0] quad;
    logic              fold;
    logic [BANG_W-1:0] ang_f;

    // fold into [-90, 90) degrees
    always_comb
    begin
        quad  = ang + 32'h4000_0000;
        fold  = quad[BANG_W-1];
        ang_f = fold ? ang + 32'h8000_0000 : ang;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= GAIN_INV;
            y_reg[0]   <= '0;
            z_reg[0]   <= CW'(signed'(ang_f));
            neg_reg[0] <= fold;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        cw_t dx;
        cw_t dy;
        cw_t at;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = CW'(atan_tab(5'(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign sin_out = neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    assign cos_out = neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];

endmodule

[hw/rtl/gcd_acos.sv]
module gcd_acos
    import gcd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] c,
    output logic        [31:0] theta
);

    localparam logic [61:0] ONE_Q60   = 62'd1 << 60;
    localparam cw_t         HALF_TURN = 34'sh0_8000_0000;

    logic signed [31:0] ca_reg;
    logic        [61:0] sq_reg;
    logic signed [63:0] sq_full;

    logic        [61:0] n_reg  [0:SQRT_STEPS];
    logic        [61:0] r_reg  [0:SQRT_STEPS];
    logic signed [31:0] cs_reg [0:SQRT_STEPS];

    cw_t  x_reg  [0:CORDIC_STEPS];
    cw_t  y_reg  [0:CORDIC_STEPS];
    cw_t  z_reg  [0:CORDIC_STEPS];
    logic cn_reg [0:CORDIC_STEPS];

    logic [31:0] abs_c;
    cw_t         z_adj;
    logic [31:0] theta_next;
    logic [31:0] theta_reg;

    assign sq_full = c * c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg    <= c;
            sq_reg    <= sq_full[61:0];
            n_reg[0]  <= ONE_Q60 - sq_reg;
            r_reg[0]  <= '0;
            cs_reg[0] <= ca_reg;
        end
    end

    // integer square root, two bits of the radicand per stage
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - i));
        logic [61:0] trial;

        assign trial = r_reg[i] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_reg[i] >= trial)
                begin
                    n_reg[i+1] <= n_reg[i] - trial;
                    r_reg[i+1] <= (r_reg[i] >> 1) + BIT;
                end
                else
                begin
                    n_reg[i+1] <= n_reg[i];
                    r_reg[i+1] <= r_reg[i] >> 1;
                end
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    assign abs_c = cs_reg[SQRT_STEPS][31] ? 32'(-cs_reg[SQRT_STEPS]) : 32'(cs_reg[SQRT_STEPS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= CW'(abs_c);
            y_reg[0]  <= CW'(r_reg[SQRT_STEPS][30:0]);
            z_reg[0]  <= '0;
            cn_reg[0] <= cs_reg[SQRT_STEPS][31];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        cw_t dx;
        cw_t dy;
        cw_t at;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = CW'(atan_tab(5'(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                cn_reg[i+1] <= cn_reg[i];
            end
        end
    end

    always_comb
    begin
        z_adj = cn_reg[CORDIC_STEPS] ? HALF_TURN - z_reg[CORDIC_STEPS] : z_reg[CORDIC_STEPS];
        priority if (z_adj[CW-1])
            theta_next = '0;
        else if (z_adj > HALF_TURN)
            theta_next = 32'(HALF_TURN);
        else
            theta_next = 32'(z_adj);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg <= theta_next;
        end
    end

    assign theta = theta_reg;

endmodule

[hw/rtl/great_circle_distance_core.sv]
// Great-circle distance by the spherical law of cosines.
// Slave stream: one point pair per transfer; tdata holds lat_a, lon_a, lat_b,
// lon_b (degrees * 2^16, two's complement). Master stream: one distance per
// transfer, km * 2^8, unsigned.
// The pipeline has PIPE_DEPTH stages from input transfer to output valid:
// 5 stages of angle conversion, 31 of sin/cos CORDIC, 4 of product and sum,
// 65 of square root and arc cosine CORDIC, 1 output register.
// Throughput is one transfer per cycle while the receiver does not stall; every stage holds one pair.
// The whole pipeline advances together while the output register is empty
// or being taken. When the receiver stalls with a valid result, the pipeline
// freezes and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block keeps no other state.
`include "great_circle_distance_core_macros.svh"

module great_circle_distance_core
    import gcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata    // distance[22:0]
);

    localparam logic signed [63:0] RND30 = 64'sd1 <<< 29;
    localparam logic signed [31:0] ONE30 = 32'sd1 <<< 30;

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;

    logic signed [MAG_W-1:0] v_in [0:2];

    logic [MAG_W-1:0]        mag_reg  [0:2];
    logic                    neg1_reg [0:2];
    logic [2*MAG_W-1:0]      prod_reg [0:2];
    logic [MAG_W-1:0]        mag2_reg [0:2];
    logic                    neg2_reg [0:2];
    logic [QUOT_W-1:0]       quo_reg  [0:2];
    logic [REM_W-1:0]        rem_reg  [0:2];
    logic                    neg3_reg [0:2];
    logic [LO_W-1:0]         lo_reg   [0:2];
    logic [QUOT_W-1:0]       quo4_reg [0:2];
    logic                    neg4_reg [0:2];
    logic [BANG_W-1:0]       ang_reg  [0:2];

    cw_t sa, ca, sb, cb, cd;

    logic signed [63:0] pcc_reg, pss_reg, pss_t_reg, pss_m_reg, ptc_reg;
    cw_t                cd_p_reg, cd_t_reg, t_reg;
    logic signed [63:0] s_sum, s_rnd;
    logic signed [31:0] s30_next, s30_reg;

    logic [31:0] theta;
    logic [63:0] dscaled;
    logic [31:0] dist_full;
    logic [DIST_W-1:0] dist_reg;

    assign en       = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = {1'b0, dist_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    assign v_in[0] = MAG_W'(signed'(s_tdata[23:0]));
    assign v_in[1] = MAG_W'(signed'(s_tdata[72:49]));
    assign v_in[2] = MAG_W'(signed'(s_tdata[48:24])) - MAG_W'(signed'(s_tdata[97:73]));

    // degrees -> binary angle, divide by 45 through two reciprocal products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg1_reg[k] <= v_in[k][MAG_W-1];
                mag_reg[k]  <= v_in[k][MAG_W-1] ? MAG_W'(-v_in[k]) : MAG_W'(v_in[k]);

                prod_reg[k] <= mag_reg[k] * RECIP_HI;
                mag2_reg[k] <= mag_reg[k];
                neg2_reg[k] <= neg1_reg[k];

                quo_reg[k]  <= prod_reg[k][RECIP_HI_K +: QUOT_W];
                rem_reg[k]  <= REM_W'(mag2_reg[k]
                               - MAG_W'(prod_reg[k][RECIP_HI_K +: QUOT_W] * DIV_N));
                neg3_reg[k] <= neg2_reg[k];

                lo_reg[k]   <= LO_W'(((39'(rem_reg[k]) << BIN_SHIFT) + 39'(HALF_BIAS))
                               * 39'(RECIP_LO) >> RECIP_LO_K);
                quo4_reg[k] <= quo_reg[k];
                neg4_reg[k] <= neg3_reg[k];

                ang_reg[k]  <= neg4_reg[k]
                    ? BANG_W'(-((BANG_W'(quo4_reg[k]) << BIN_SHIFT) + BANG_W'(lo_reg[k])))
                    : BANG_W'((BANG_W'(quo4_reg[k]) << BIN_SHIFT) + BANG_W'(lo_reg[k]));
            end
        end
    end

    gcd_sincos u_sc_lat_a
    (
        .clk     (clk),
        .en      (en),
        .ang     (ang_reg[0]),
        .sin_out (sa),
        .cos_out (ca)
    );

    gcd_sincos u_sc_lat_b
    (
        .clk     (clk),
        .en      (en),
        .ang     (ang_reg[1]),
        .sin_out (sb),
        .cos_out (cb)
    );

    gcd_sincos u_sc_dlon
    (
        .clk     (clk),
        .en      (en),
        .ang     (ang_reg[2]),
        .sin_out (),
        .cos_out (cd)
    );

    always_comb
    begin
        s_sum = pss_m_reg + ptc_reg;
        s_rnd = (s_sum + RND30) >>> 30;
        priority if (s_rnd > 64'(ONE30))
            s30_next = ONE30;
        else if (s_rnd < -64'(ONE30))
            s30_next = -ONE30;
        else
            s30_next = 32'(s_rnd);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcc_reg   <= 64'(ca) * 64'(cb);
            pss_reg   <= 64'(sa) * 64'(sb);
            cd_p_reg  <= cd;

            t_reg     <= CW'((pcc_reg + RND30) >>> 30);
            pss_t_reg <= pss_reg;
            cd_t_reg  <= cd_p_reg;

            ptc_reg   <= 64'(t_reg) * 64'(cd_t_reg);
            pss_m_reg <= pss_t_reg;

            s30_reg   <= s30_next;
        end
    end

    gcd_acos u_acos
    (
        .clk   (clk),
        .en    (en),
        .c     (s30_reg),
        .theta (theta)
    );

    always_comb
    begin
        dscaled   = ((64'(theta) * 64'(KM_PER_TURN)) << DIST_FRAC_BITS) + 64'h8000_0000;
        dist_full = dscaled[63:32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= (dist_full > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : dist_full[DIST_W-1:0];
        end
    end

    `GCD_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken during output stall")
    `GCD_ASSERT_IMP(a_sum_clamped, vld_reg[PIPE_PRE + SC_LAT + PIPE_MID - 1], (s30_reg <= ONE30) && (s30_reg >= -ONE30), "cosine sum out of range")
    `GCD_ASSERT_IMP(a_theta_range, vld_reg[PIPE_DEPTH - 2], theta <= 32'h8000_0000, "angle beyond half turn")
    `GCD_ASSERT(a_no_bubble_stall, (!m_tvalid) |-> s_tready, "ready low with empty output")

endmodule
